// ===== src/bpc_pkg.sv =====
// shared types and constants for the barometric compensation core
package bpc_pkg;

  // partial product chunk width and adder tree depth of the pipelined multiplier
  localparam int CHUNK      = 32;
  localparam int MUL_LEVELS = 4;
  localparam int MUL_LAT    = MUL_LEVELS + 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_B = 2'd2;

  typedef struct packed {
    logic [23:0] press_raw;
    logic [23:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic [23:0]        pressure;
    logic signed [15:0] temperature;
    logic               clipped;
  } result_t;

endpackage

// ===== src/bpc_dly.sv =====
// enable-gated register delay line
module bpc_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// ===== src/bpc_mul.sv =====
// pipelined signed multiplier built from 32x32 partial products and a registered adder tree
module bpc_mul #(
  parameter int WA = 8,
  parameter int WB = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int C     = bpc_pkg::CHUNK;
  localparam int LV    = bpc_pkg::MUL_LEVELS;
  localparam int NA    = (WA + C - 1) / C;
  localparam int NB    = (WB + C - 1) / C;
  localparam int NPP   = NA * NB;
  localparam int NLEAF = 2 ** LV;
  localparam int WP    = C * (NA + NB);

  logic [WA-1:0]      a_abs;
  logic [WB-1:0]      b_abs;
  logic [NA*C-1:0]    ma;
  logic [NB*C-1:0]    mb;
  logic [LV+1:0]      ng;
  logic [2*C-1:0]     pp [NPP];
  logic [WP-1:0]      tr [LV+1][NLEAF];
  logic [WA+WB-1:0]   mag;

  // magnitudes; the most negative value maps onto its own unsigned magnitude
  assign a_abs = a[WA-1] ? WA'(-a) : WA'(a);
  assign b_abs = b[WB-1] ? WB'(-b) : WB'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ma <= (NA*C)'(a_abs);
      mb <= (NB*C)'(b_abs);
      ng <= {ng[LV:0], a[WA-1] ^ b[WB-1]};
    end
  end

  for (genvar i = 0; i < NA; i++) begin : g_ra
    for (genvar j = 0; j < NB; j++) begin : g_rb
      assign pp[i*NB+j] = ma[i*C +: C] * mb[j*C +: C];
    end
  end

  for (genvar k = 0; k < NLEAF; k++) begin : g_leaf
    if (k < NPP) begin : g_used
      always_ff @(posedge clk) begin
        if (en) begin
          tr[0][k] <= WP'(pp[k]) << (C * (k / NB + k % NB));
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          tr[0][k] <= '0;
        end
      end
    end
  end

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    for (genvar k = 0; k < (NLEAF >> l); k++) begin : g_node
      always_ff @(posedge clk) begin
        if (en) begin
          tr[l][k] <= tr[l-1][2*k] + tr[l-1][2*k+1];
        end
      end
    end
  end

  assign mag = tr[LV][0][WA+WB-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p <= ng[LV+1] ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

// ===== src/baro_pressure_compensation_core.sv =====
// Barometric pressure/temperature compensation core. One raw pressure/temperature pair
// enters per clock while sample_stall is low; its latency is set by the chain of five
// pipelined multipliers that evaluate the temperature and pressure polynomials in exact
// wide fixed point. A two-entry output queue lets the pipeline keep taking samples while
// one result waits; sample_stall rises only when both entries are full. Calibration
// registers are written through the cfg port (always ready) and must only change while
// no sample is in flight.
module baro_pressure_compensation_core #(
  parameter int PRESSURE_FRAC_BITS = 6,
  parameter int TEMP_FRAC_BITS     = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  bpc_pkg::sample_t                  sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bpc_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int L    = bpc_pkg::MUL_LAT;
  localparam int TN_T = 4 + L;
  localparam int S_A  = TN_T + L + 1;
  localparam int S_B  = S_A + L + 1;
  localparam int S_C  = S_B + L + 1;
  localparam int S_D  = S_C + 1;
  localparam int S_E  = S_D + L + 1;
  localparam int TS   = 48 - TEMP_FRAC_BITS;
  localparam int PS   = 181 - PRESSURE_FRAC_BITS;

  localparam logic signed [61:0]  T_HALF = 62'sd1 << (TS - 1);
  localparam logic signed [221:0] P_HALF = 222'sd1 << (PS - 1);

  // calibration registers
  logic [39:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpc_pkg::CFG_CAL_TEMP:    cal_temp    <= cfg_data[39:0];
        bpc_pkg::CFG_CAL_PRESS_A: cal_press_a <= cfg_data;
        bpc_pkg::CFG_CAL_PRESS_B: cal_press_b <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [16:0] p1, p2;
  logic signed [15:0] p9;

  assign t1  = cal_temp[15:0];
  assign t2  = cal_temp[31:16];
  assign t3  = $signed(cal_temp[39:32]);
  assign p1  = $signed({cal_press_a[15], cal_press_a[15:0]}) - 17'sd16384;
  assign p2  = $signed({cal_press_a[31], cal_press_a[31:16]}) - 17'sd16384;
  assign p3  = $signed(cal_press_a[39:32]);
  assign p4  = $signed(cal_press_a[47:40]);
  assign p5  = cal_press_a[63:48];
  assign p6  = cal_press_b[15:0];
  assign p7  = $signed(cal_press_b[23:16]);
  assign p8  = $signed(cal_press_b[31:24]);
  assign p9  = $signed(cal_press_b[47:32]);
  assign p10 = $signed(cal_press_b[55:48]);
  assign p11 = $signed(cal_press_b[63:56]);

  // pipeline advance and valid tracking
  logic           en;
  logic [1:0]     cnt;
  logic [S_E-1:0] vld;

  assign en           = (cnt != 2'd2);
  assign sample_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_E-2:0], sample_valid};
    end
  end

  // temperature front end
  logic [23:0]        rp1, rt1;
  logic signed [24:0] d2, d3, d4;
  logic signed [32:0] rpk2, dt3;
  logic signed [35:0] m4;
  logic signed [60:0] tn;

  always_ff @(posedge clk) begin
    if (en) begin
      rp1  <= sample.press_raw;
      rt1  <= sample.raw_temperature;
      d2   <= $signed({1'b0, rt1}) - $signed({1'b0, t1, 8'b0});
      rpk2 <= $signed({1'b0, rp1}) * p11;
      dt3  <= d2 * t3;
      d3   <= d2;
      m4   <= $signed({1'b0, t2, 18'b0}) + dt3;
      d4   <= d3;
    end
  end

  // tn = d * (T2 * 2^18 + d * T3)
  bpc_mul #(.WA(25), .WB(36)) u_tn (.clk(clk), .en(en), .a(d4), .b(m4), .p(tn));

  // temperature rounding and saturation
  logic signed [61:0] tr12, tqf;
  logic signed [15:0] tq13;
  logic               tclip13;
  logic [16:0]        tq_e;

  assign tqf = tr12 >>> TS;

  always_ff @(posedge clk) begin
    if (en) begin
      tr12 <= tn + T_HALF;
      if (tqf > 62'sd32767) begin
        tq13    <= 16'sh7fff;
        tclip13 <= 1'b1;
      end else if (tqf < -62'sd32768) begin
        tq13    <= 16'sh8000;
        tclip13 <= 1'b1;
      end else begin
        tq13    <= tqf[15:0];
        tclip13 <= 1'b0;
      end
    end
  end

  bpc_dly #(.W(17), .N(S_E - TN_T - 2)) u_dly_tq (
    .clk(clk), .en(en), .d({tclip13, tq13}), .q(tq_e));

  // aligned copies of tn and rp
  logic [60:0] tn_a, tn_b;
  logic [23:0] rp_a, rp_d;
  logic [32:0] rpk_a;

  bpc_dly #(.W(61), .N(S_A - TN_T)) u_dly_tna (.clk(clk), .en(en), .d(tn), .q(tn_a));
  bpc_dly #(.W(61), .N(S_B - S_A)) u_dly_tnb (.clk(clk), .en(en), .d(tn_a), .q(tn_b));
  bpc_dly #(.W(24), .N(S_A - 1)) u_dly_rpa (.clk(clk), .en(en), .d(rp1), .q(rp_a));
  bpc_dly #(.W(24), .N(S_D - S_A)) u_dly_rpd (.clk(clk), .en(en), .d(rp_a), .q(rp_d));
  bpc_dly #(.W(33), .N(S_A - 3)) u_dly_rpk (.clk(clk), .en(en), .d(rpk2), .q(rpk_a));

  // first polynomial step: P4, P8, P10 times tn
  logic signed [68:0] mp4, mp8, mp10;

  bpc_mul #(.WA(8), .WB(61)) u_m4 (.clk(clk), .en(en), .a(p4), .b(tn), .p(mp4));
  bpc_mul #(.WA(8), .WB(61)) u_m8 (.clk(clk), .en(en), .a(p8), .b(tn), .p(mp8));
  bpc_mul #(.WA(8), .WB(61)) u_m10 (.clk(clk), .en(en), .a(p10), .b(tn), .p(mp10));

  logic signed [69:0] h3, g3;
  logic signed [70:0] x1;

  always_ff @(posedge clk) begin
    if (en) begin
      h3 <= mp4 + $signed({p3, 53'b0});
      g3 <= mp8 + $signed({p7, 55'b0});
      x1 <= mp10 + $signed({p9, 48'b0}) + $signed({rpk_a, 31'b0});
    end
  end

  // second step
  logic signed [130:0] h3t, g3t;
  logic signed [95:0]  rpx1;

  bpc_mul #(.WA(70), .WB(61)) u_h3t (
    .clk(clk), .en(en), .a(h3), .b($signed(tn_a)), .p(h3t));
  bpc_mul #(.WA(70), .WB(61)) u_g3t (
    .clk(clk), .en(en), .a(g3), .b($signed(tn_a)), .p(g3t));
  bpc_mul #(.WA(25), .WB(71)) u_rpx1 (
    .clk(clk), .en(en), .a($signed({1'b0, rp_a})), .b(x1), .p(rpx1));

  logic signed [131:0] h2, g2;

  always_ff @(posedge clk) begin
    if (en) begin
      h2 <= h3t + $signed({p2, 104'b0});
      g2 <= g3t + $signed({1'b0, p6, 105'b0});
    end
  end

  // third step
  logic signed [192:0] h2t, g2t;

  bpc_mul #(.WA(132), .WB(61)) u_h2t (
    .clk(clk), .en(en), .a(h2), .b($signed(tn_b)), .p(h2t));
  bpc_mul #(.WA(132), .WB(61)) u_g2t (
    .clk(clk), .en(en), .a(g2), .b($signed(tn_b)), .p(g2t));

  logic signed [193:0] h1, g1;
  logic [95:0]         rpx1_c;
  logic [193:0]        g1_e;

  bpc_dly #(.W(96), .N(S_C - S_A - L)) u_dly_rpx (
    .clk(clk), .en(en), .d(rpx1), .q(rpx1_c));

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= h2t + $signed({p1, 161'b0});
      g1 <= g2t + $signed({1'b0, p5, 162'b0});
    end
  end

  bpc_dly #(.W(194), .N(S_E - 1 - S_C)) u_dly_g1 (.clk(clk), .en(en), .d(g1), .q(g1_e));

  // inner raw-pressure polynomial, then the last multiply by rp
  logic signed [194:0] inner2;
  logic signed [219:0] rpi2;

  always_ff @(posedge clk) begin
    if (en) begin
      inner2 <= h1 + $signed({rpx1_c, 85'b0});
    end
  end

  bpc_mul #(.WA(25), .WB(195)) u_rpi2 (
    .clk(clk), .en(en), .a($signed({1'b0, rp_d})), .b(inner2), .p(rpi2));

  logic signed [221:0] pn, pq;

  always_ff @(posedge clk) begin
    if (en) begin
      pn <= $signed({g1_e, 22'b0}) + rpi2 + P_HALF;
    end
  end

  // pressure rounding and saturation
  logic             pneg, pbig, push, pop;
  bpc_pkg::result_t fin, q0, q1;

  assign pq   = pn >>> PS;
  assign pneg = pn[221];
  assign pbig = !pneg && (pq > 222'sd16777215);

  always_comb begin
    fin.temperature = $signed(tq_e[15:0]);
    fin.clipped     = tq_e[16] | pneg | pbig;
    if (pneg) begin
      fin.pressure = '0;
    end else if (pbig) begin
      fin.pressure = 24'hffffff;
    end else begin
      fin.pressure = pq[23:0];
    end
  end

  // two-entry output queue
  assign push         = en && vld[S_E-1];
  assign pop          = result_valid && !result_stall;
  assign result_valid = (cnt != 2'd0);
  assign result       = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if ((cnt == 2'd0 && push) || (cnt == 2'd1 && push && pop)) begin
      q0 <= fin;
    end else if (cnt == 2'd2 && pop) begin
      q0 <= q1;
    end
    if (cnt == 2'd1 && push && !pop) begin
      q1 <= fin;
    end
  end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the barometric compensation core
`timescale 1ns / 100ps

module tb;

  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class comp_scoreboard;
    logic [63:0]      cal_temp, cal_press_a, cal_press_b;
    bpc_pkg::result_t expected_q[$];
    int               mismatches;

    function new();
      cal_temp = '0;
      cal_press_a = '0;
      cal_press_b = '0;
      mismatches = 0;
    endfunction

    function void write_cal(logic [bpc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        bpc_pkg::CFG_CAL_TEMP:    cal_temp = {24'd0, data[39:0]};
        bpc_pkg::CFG_CAL_PRESS_A: cal_press_a = data;
        bpc_pkg::CFG_CAL_PRESS_B: cal_press_b = data;
        default: ;
      endcase
    endfunction

    function logic signed [255:0] term(longint signed coef, logic signed [255:0] a,
                                       logic signed [255:0] b, int k);
      logic signed [255:0] c;
      c = coef;
      return (c * a * b) <<< k;
    endfunction

    function bpc_pkg::result_t compensate(bpc_pkg::sample_t s);
      longint signed d, tn, tq, t1, t2, t3;
      longint signed p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
      logic signed [255:0] one, bt, bt2, bt3, br, br2, br3, acc;
      bpc_pkg::result_t r;
      t1 = longint'({48'd0, cal_temp[15:0]});
      t2 = longint'({48'd0, cal_temp[31:16]});
      t3 = longint'($signed(cal_temp[39:32]));
      p1 = longint'($signed(cal_press_a[15:0])) - 16384;
      p2 = longint'($signed(cal_press_a[31:16])) - 16384;
      p3 = longint'($signed(cal_press_a[39:32]));
      p4 = longint'($signed(cal_press_a[47:40]));
      p5 = longint'({48'd0, cal_press_a[63:48]});
      p6 = longint'({48'd0, cal_press_b[15:0]});
      p7 = longint'($signed(cal_press_b[23:16]));
      p8 = longint'($signed(cal_press_b[31:24]));
      p9 = longint'($signed(cal_press_b[47:32]));
      p10 = longint'($signed(cal_press_b[55:48]));
      p11 = longint'($signed(cal_press_b[63:56]));
      r.clipped = 1'b0;
      // linearized temperature scaled by 2^48
      d = longint'({40'd0, s.raw_temperature}) - t1 * 256;
      tn = d * t2 * 262144 + d * d * t3;
      tq = (tn + (64'sd1 <<< 39)) >>> 40;
      if (tq > 32767) begin
        tq = 32767;
        r.clipped = 1'b1;
      end
      if (tq < -32768) begin
        tq = -32768;
        r.clipped = 1'b1;
      end
      r.temperature = tq[15:0];
      // pressure sum scaled by 2^181
      one = 1;
      bt = tn;
      bt2 = bt * bt;
      bt3 = bt2 * bt;
      br = longint'({40'd0, s.press_raw});
      br2 = br * br;
      br3 = br2 * br;
      acc = term(p5, one, one, 184) + term(p6, bt, one, 127) + term(p7, bt2, one, 77)
          + term(p8, bt3, one, 22) + term(p1, one, br, 161) + term(p2, bt, br, 104)
          + term(p3, bt2, br, 53) + term(p4, bt3, br, 0) + term(p9, one, br2, 133)
          + term(p10, bt, br2, 85) + term(p11, one, br3, 116);
      acc = (acc + (one <<< 174)) >>> 175;
      if (acc[255]) begin
        r.pressure = '0;
        r.clipped = 1'b1;
      end else if (acc > 256'hFFFFFF) begin
        r.pressure = 24'hFFFFFF;
        r.clipped = 1'b1;
      end else begin
        r.pressure = acc[23:0];
      end
      return r;
    endfunction

    function void note_sample(bpc_pkg::sample_t s);
      expected_q.push_back(compensate(s));
    endfunction

    function void check_result(bpc_pkg::result_t got);
      bpc_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.pressure !== want.pressure || got.temperature !== want.temperature ||
          got.clipped !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected p=%h t=%h c=%b got p=%h t=%h c=%b",
                   want.pressure, want.temperature, want.clipped,
                   got.pressure, got.temperature, got.clipped);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  bpc_pkg::sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  bpc_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  comp_scoreboard sb = new();
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  baro_pressure_compensation_core dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 99);
      if (mode < 40) result_stall <= 1'b0;
      else if (mode < 70) result_stall <= ($urandom_range(0, 3) == 0);
      else result_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [bpc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_cal(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(logic [23:0] rp, logic [23:0] rt);
    @(negedge clk);
    sample_valid <= 1'b1;
    sample <= '{press_raw: rp, raw_temperature: rt};
    do @(posedge clk); while (sample_stall);
    sb.note_sample('{press_raw: rp, raw_temperature: rt});
  endtask

  task automatic configure(logic [39:0] ct, logic [63:0] pa, logic [63:0] pb);
    write_reg(bpc_pkg::CFG_CAL_TEMP, {24'd0, ct});
    write_reg(bpc_pkg::CFG_CAL_PRESS_A, pa);
    write_reg(bpc_pkg::CFG_CAL_PRESS_B, pb);
  endtask

  // random traffic in bursts, mostly near the calibrated temperature window
  task automatic random_phase(int count, bit gaps);
    int burst, g;
    logic [23:0] rp, rt;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      rp = 24'($urandom);
      if ($urandom_range(0, 3) != 0)
        rt = {sb.cal_temp[15:0], 8'd0} + 24'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      else
        rt = 24'($urandom);
      if ($urandom_range(0, 9) == 0) rp = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd0;
      send_sample(rp, rt);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        g = gaps ? $urandom_range(0, 12) : 0;
        if (g > 0) begin
          @(negedge clk);
          sample_valid <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes of raw fields under reset calibration, then under several fixed calibrations
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    wait_drained();
    configure(40'h00_4A00_6A00, {16'h7800, 8'h05, 8'hF8, 16'hE000, 16'h1C00},
              {8'hF9, 8'h12, 16'h0C00, 8'hFC, 8'h06, 16'h9600});
    write_reg(CFG_UNUSED, '1);
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h6B0000, 24'h6A0000);
    send_sample(24'h6B0000, 24'h6A0080);
    send_sample(24'h000001, 24'h6A0001);
    send_sample(24'hFFFFFF, 24'h6A0000);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'h7FFFFF, 24'h7FFFFF);
    wait_drained();
    configure('1, '1, '1);
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFF00, 24'hFFFF00);
    wait_drained();
    configure('0, {16'd0, 8'h80, 8'h80, 16'h8000, 16'h8000},
              {8'h80, 8'h80, 16'h8000, 8'h80, 8'h80, 16'd0});
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h123456, 24'd0);
    wait_drained();

    // random phases over several calibrations
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        configure(40'h00_4A00_6A00, {16'h7800, 8'h05, 8'hF8, 16'hE000, 16'h1C00},
                  {8'hF9, 8'h12, 16'h0C00, 8'hFC, 8'h06, 16'h9600});
      else
        configure(40'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom});
      if ($urandom_range(0, 1) != 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
      if (ph == 2) hold_request = 1'b1;
      random_phase(280, ph != 2);
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
